// ===== hdl/bmr_pkg.sv =====
// ----------------------------------------------------------------------------
// bmr_pkg
// Shared types, codes and helpers for the bidirectional motor ramp PWM drive.
// ----------------------------------------------------------------------------
`default_nettype none

package bmr_pkg;

    // item kinds carried on s_tuser
    localparam logic [1:0] FUNC_CHAR = 2'd0;
    localparam logic [1:0] FUNC_TICK = 2'd1;
    localparam logic [1:0] FUNC_PWM  = 2'd2;

    // operating modes
    localparam logic [2:0] MODE_STOPPED = 3'd0;
    localparam logic [2:0] MODE_CHOOSE  = 3'd1;
    localparam logic [2:0] MODE_DIR     = 3'd2;
    localparam logic [2:0] MODE_SPEED   = 3'd3;
    localparam logic [2:0] MODE_TERM    = 3'd4;
    localparam logic [2:0] MODE_POT     = 3'd5;

    // command characters
    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_P    = 8'h70;
    localparam logic [7:0] CH_T    = 8'h74;
    localparam logic [7:0] CH_H    = 8'h68;
    localparam logic [7:0] CH_A    = 8'h61;
    localparam logic [7:0] CH_S    = 8'h73;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_5    = 8'h35;
    localparam logic [7:0] CH_9    = 8'h39;

    // configuration register indexes
    localparam logic CFG_RAMP_STEP = 1'b0;
    localparam logic CFG_TICKS_PCT = 1'b1;

    // reset values of the configuration registers
    localparam logic [6:0]  RAMP_STEP_RST = 7'd5;
    localparam logic [15:0] TICKS_PCT_RST = 16'd800;

    // numeric constants
    localparam logic [6:0]  FULL_DUTY  = 7'd100;
    localparam logic [6:0]  ZERO_SPEED = 7'd99;
    localparam logic [12:0] ADC_SPAN   = 13'd4095;
    localparam int          PHASE_W    = 23;

    typedef logic signed [7:0] speed_t;
    typedef logic [PHASE_W-1:0] phase_t;

    // registered item handed from the input stage to the core
    typedef struct packed {
        logic [1:0] func;
        logic [7:0] char_code;
        speed_t     pot_target;
    } item_t;

    // configuration seen by the core
    typedef struct packed {
        logic [6:0]  ramp_step;
        logic [15:0] ticks_per_percent;
    } cfg_t;

    // one result word
    typedef struct packed {
        logic [2:0] mode_now;
        logic       drive_ccw;
        logic       drive_cw;
        logic [6:0] duty_percent;
        speed_t     speed_now;
    } result_t;

    typedef struct packed {
        logic       hit;
        logic [6:0] value;
    } digit_t;

    // speed digits: 5..9 give ten times the digit, 0 gives 99
    function automatic digit_t digit_decode(input logic [7:0] c);
        digit_t d;
        logic [3:0] n;
        n = c[3:0];
        d.hit   = 1'b0;
        d.value = '0;
        if (c >= CH_5 && c <= CH_9) begin
            d.hit   = 1'b1;
            d.value = 7'({3'b000, n} * 7'd10);
        end else if (c == CH_0) begin
            d.hit   = 1'b1;
            d.value = ZERO_SPEED;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/bidirectional_motor_ramp_pwm_top.sv =====
// ----------------------------------------------------------------------------
// bidirectional_motor_ramp_pwm_top
// Bidirectional DC motor drive with speed ramp and PWM phase counter.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_        in         tuser: func; tdata: char_code, adc_sample
//  m_        out        tdata: speed_now, duty_percent, drive_cw, drive_ccw, mode_now
//  cfg_      in         index 0 ramp_step, index 1 ticks_per_percent
//
//  one word per cycle unless m_tready stalls the output; two register stages
//  (potentiometer map, then state update): the input register takes the
//  word, then the output register holds its result
//  reset is synchronous, active low, and puts the drive in stopped mode
//  a stall on m_tready holds both stages and drops s_tready
// ----------------------------------------------------------------------------
`default_nettype none

module bidirectional_motor_ramp_pwm_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [7:0] char_code, [19:8] adc_sample, zero pad
    input  wire logic [1:0]  s_tuser,   // [1:0] func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] speed_now, [14:8] duty_percent,
                                        // [15] drive_cw, [16] drive_ccw,
                                        // [19:17] mode_now, zero pad
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_wdata
);

    logic               advance;
    bmr_pkg::item_t     item;
    logic               item_valid;
    bmr_pkg::result_t   result;
    logic               result_valid;
    bmr_pkg::cfg_t      cfg_reg;

    // pipeline moves whenever the result register is free or being taken
    assign advance  = !result_valid || m_tready;
    assign s_tready = advance;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ramp_step         <= bmr_pkg::RAMP_STEP_RST;
            cfg_reg.ticks_per_percent <= bmr_pkg::TICKS_PCT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                bmr_pkg::CFG_RAMP_STEP: cfg_reg.ramp_step         <= cfg_wdata[6:0];
                bmr_pkg::CFG_TICKS_PCT: cfg_reg.ticks_per_percent <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    bmr_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .in_valid   (s_tvalid),
        .in_func    (s_tuser),
        .in_char    (s_tdata[7:0]),
        .in_adc     (s_tdata[19:8]),
        .item       (item),
        .item_valid (item_valid)
    );

    bmr_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (advance),
        .item         (item),
        .item_valid   (item_valid),
        .cfg          (cfg_reg),
        .result       (result),
        .result_valid (result_valid)
    );

    // output word
    assign m_tvalid = result_valid;
    assign m_tdata  = {4'b0000, result.mode_now, result.drive_ccw, result.drive_cw,
                       result.duty_percent, result.speed_now};

endmodule

`default_nettype wire

// ===== hdl/bmr_in_stage.sv =====
// ----------------------------------------------------------------------------
// bmr_in_stage
// Input register; maps the potentiometer sample to a signed speed target.
// ----------------------------------------------------------------------------
`default_nettype none

module bmr_in_stage (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            advance,
    input  wire logic            in_valid,
    input  wire logic [1:0]      in_func,
    input  wire logic [7:0]      in_char,
    input  wire logic [11:0]     in_adc,
    output bmr_pkg::item_t       item,
    output logic                 item_valid
);

    logic            valid_reg;
    bmr_pkg::item_t  item_reg;
    bmr_pkg::item_t  item_next;

    logic [12:0] twice;
    logic [11:0] mag;
    logic        neg;
    logic [18:0] prod;
    logic [6:0]  q0;
    logic [12:0] rem0;
    logic [6:0]  quot;

    // (2v-4095)*100/4095 toward zero: work on the magnitude, restore the sign
    always_comb begin
        twice = {in_adc, 1'b0};
        if (in_adc[11]) begin
            mag = 12'(twice - bmr_pkg::ADC_SPAN);
            neg = 1'b0;
        end else begin
            mag = 12'(bmr_pkg::ADC_SPAN - twice);
            neg = 1'b1;
        end
        prod = 19'(mag) * 19'd100;
        // divide by 4096-1: shift estimate, remainder stays under twice the span
        q0   = prod[18:12];
        rem0 = {1'b0, prod[11:0]} + 13'(q0);
        quot = (rem0 >= bmr_pkg::ADC_SPAN) ? 7'(q0 + 7'd1) : q0;
        item_next.func       = in_func;
        item_next.char_code  = in_char;
        item_next.pot_target = neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    end

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (advance && in_valid) begin
            item_reg <= item_next;
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

`default_nettype wire

// ===== hdl/bmr_core.sv =====
// ----------------------------------------------------------------------------
// bmr_core
// Mode machine, speed ramp, PWM phase counter and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bmr_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            advance,
    input  wire bmr_pkg::item_t  item,
    input  wire logic            item_valid,
    input  wire bmr_pkg::cfg_t   cfg,
    output bmr_pkg::result_t     result,
    output logic                 result_valid
);

    logic [2:0]        mode_reg,   mode_next;
    bmr_pkg::speed_t   cur_reg,    cur_next;
    bmr_pkg::speed_t   tgt_reg,    tgt_next;
    logic              ccw_reg,    ccw_next;
    logic              phase_reg,  phase_next;
    bmr_pkg::phase_t   left_reg,   left_next;
    logic              valid_reg;
    bmr_pkg::result_t  res_reg,    res_next;

    bmr_pkg::digit_t   dig;
    bmr_pkg::speed_t   dig_pos;
    bmr_pkg::speed_t   tgt_eff;
    logic signed [9:0] cur_w, tgt_w, step_w, sum_w;
    logic [6:0]        duty_cur, duty_new;
    bmr_pkg::phase_t   len_hi, len_lo, len_try, len_alt;
    logic              ph_try;

    always_comb begin
        dig     = bmr_pkg::digit_decode(item.char_code);
        dig_pos = $signed({1'b0, dig.value});
        tgt_eff = (mode_reg == bmr_pkg::MODE_POT) ? item.pot_target : tgt_reg;
        cur_w   = 10'(cur_reg);
        tgt_w   = 10'(tgt_eff);
        step_w  = $signed({3'b000, cfg.ramp_step});
        sum_w   = '0;

        // phase lengths from the present duty
        duty_cur = cur_reg[7] ? 7'(-cur_reg) : cur_reg[6:0];
        len_hi   = bmr_pkg::PHASE_W'(duty_cur) * bmr_pkg::PHASE_W'(cfg.ticks_per_percent);
        len_lo   = bmr_pkg::PHASE_W'(bmr_pkg::FULL_DUTY - duty_cur)
                   * bmr_pkg::PHASE_W'(cfg.ticks_per_percent);
        ph_try   = !phase_reg;
        len_try  = ph_try ? len_hi : len_lo;
        len_alt  = ph_try ? len_lo : len_hi;

        mode_next  = mode_reg;
        cur_next   = cur_reg;
        tgt_next   = tgt_reg;
        ccw_next   = ccw_reg;
        phase_next = phase_reg;
        left_next  = left_reg;

        unique case (item.func)
            bmr_pkg::FUNC_CHAR: begin
                unique case (mode_reg)
                    bmr_pkg::MODE_STOPPED: begin
                        if (item.char_code == bmr_pkg::CH_STAR && cur_reg == 8'sd0) begin
                            mode_next = bmr_pkg::MODE_CHOOSE;
                        end
                    end
                    bmr_pkg::MODE_CHOOSE: begin
                        if (item.char_code == bmr_pkg::CH_P) begin
                            mode_next = bmr_pkg::MODE_POT;
                        end else if (item.char_code == bmr_pkg::CH_T) begin
                            mode_next = bmr_pkg::MODE_DIR;
                        end
                    end
                    bmr_pkg::MODE_DIR: begin
                        if (item.char_code == bmr_pkg::CH_H) begin
                            ccw_next  = 1'b0;
                            mode_next = bmr_pkg::MODE_SPEED;
                        end else if (item.char_code == bmr_pkg::CH_A) begin
                            ccw_next  = 1'b1;
                            mode_next = bmr_pkg::MODE_SPEED;
                        end
                    end
                    bmr_pkg::MODE_SPEED: begin
                        if (dig.hit) begin
                            tgt_next  = ccw_reg ? -dig_pos : dig_pos;
                            mode_next = bmr_pkg::MODE_TERM;
                        end
                    end
                    bmr_pkg::MODE_TERM: begin
                        priority if (item.char_code == bmr_pkg::CH_H) begin
                            if (cur_reg < 8'sd0) tgt_next = -tgt_reg;
                        end else if (item.char_code == bmr_pkg::CH_A) begin
                            if (cur_reg > 8'sd0) tgt_next = -tgt_reg;
                        end else if (dig.hit) begin
                            tgt_next = (cur_reg < 8'sd0) ? -dig_pos : dig_pos;
                        end else if (item.char_code == bmr_pkg::CH_S) begin
                            mode_next = bmr_pkg::MODE_STOPPED;
                            tgt_next  = '0;
                        end
                    end
                    bmr_pkg::MODE_POT: begin
                        if (item.char_code == bmr_pkg::CH_S) begin
                            mode_next = bmr_pkg::MODE_STOPPED;
                            tgt_next  = '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            bmr_pkg::FUNC_TICK: begin
                // ramp toward the target without passing it
                tgt_next = tgt_eff;
                if (cur_w < tgt_w) begin
                    sum_w    = cur_w + step_w;
                    cur_next = (sum_w > tgt_w) ? tgt_eff : sum_w[7:0];
                end else if (cur_w > tgt_w) begin
                    sum_w    = cur_w - step_w;
                    cur_next = (sum_w < tgt_w) ? tgt_eff : sum_w[7:0];
                end
            end
            bmr_pkg::FUNC_PWM: begin
                // count down; at phase end toggle, skipping a zero-length phase
                if (left_reg > bmr_pkg::PHASE_W'(1)) begin
                    left_next = left_reg - bmr_pkg::PHASE_W'(1);
                end else if (len_try == '0) begin
                    phase_next = phase_reg;
                    left_next  = len_alt;
                end else begin
                    phase_next = ph_try;
                    left_next  = len_try;
                end
            end
            default: begin
            end
        endcase

        // result word from the updated state
        duty_new              = cur_next[7] ? 7'(-cur_next) : cur_next[6:0];
        res_next.speed_now    = cur_next;
        res_next.duty_percent = duty_new;
        res_next.drive_cw     = phase_next && (cur_next > 8'sd0);
        res_next.drive_ccw    = phase_next && (cur_next <= 8'sd0);
        res_next.mode_now     = mode_next;
    end

    // drive state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= bmr_pkg::MODE_STOPPED;
            cur_reg   <= '0;
            tgt_reg   <= '0;
            ccw_reg   <= 1'b0;
            phase_reg <= 1'b0;
            left_reg  <= '0;
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= item_valid;
            if (item_valid) begin
                mode_reg  <= mode_next;
                cur_reg   <= cur_next;
                tgt_reg   <= tgt_next;
                ccw_reg   <= ccw_next;
                phase_reg <= phase_next;
                left_reg  <= left_next;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (advance && item_valid) begin
            res_reg <= res_next;
        end
    end

    assign result       = res_reg;
    assign result_valid = valid_reg;

endmodule

`default_nettype wire

// ===== dv/motor_drive_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// motor_drive_checker
// Watches the command, result and register ports of the motor drive. It keeps
// its own copy of the mode, speed ramp and PWM phase counter, predicts one
// result word for every accepted input word, and compares each result word
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------

module motor_drive_checker
    import bmr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,    // [7:0] char_code, [19:8] adc_sample, zero pad
    input  logic [1:0]  s_tuser,    // [1:0] func
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,    // [7:0] speed_now, [14:8] duty_percent,
                                    // [15] drive_cw, [16] drive_ccw,
                                    // [19:17] mode_now, zero pad
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    output int          mismatches,
    output int          outstanding
);

    // predicted drive state
    logic [2:0] drive_mode;
    int         speed_cur;
    int         speed_goal;
    bit         goal_ccw;
    bit         phase_high;
    int         phase_left;

    // register copies
    int         step_cfg;
    int         tpp_cfg;

    // predicted result words, oldest first
    result_t    pending_results[$];
    result_t    seen_word;
    result_t    want_word;

    function automatic int magnitude(input int v);
        return (v < 0) ? -v : v;
    endfunction

    // speed digits: 5..9 give ten times the digit, 0 gives 99
    function automatic bit speed_digit(input logic [7:0] ch, output int value);
        value = 0;
        if (ch >= CH_5 && ch <= CH_9) begin
            value = (int'(ch) - int'(CH_0)) * 10;
            return 1'b1;
        end
        if (ch == CH_0) begin
            value = 99;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic int phase_length(input bit high);
        int duty;
        duty = magnitude(speed_cur);
        return high ? duty * tpp_cfg : (100 - duty) * tpp_cfg;
    endfunction

    // command characters move the mode and set the goal
    task automatic take_char(input logic [7:0] ch);
        int value;
        bit is_digit;
        is_digit = speed_digit(ch, value);
        case (drive_mode)
            MODE_STOPPED: begin
                if (ch == CH_STAR && speed_cur == 0) drive_mode = MODE_CHOOSE;
            end
            MODE_CHOOSE: begin
                if (ch == CH_P) drive_mode = MODE_POT;
                else if (ch == CH_T) drive_mode = MODE_DIR;
            end
            MODE_DIR: begin
                if (ch == CH_H) begin
                    goal_ccw = 1'b0;
                    drive_mode = MODE_SPEED;
                end else if (ch == CH_A) begin
                    goal_ccw = 1'b1;
                    drive_mode = MODE_SPEED;
                end
            end
            MODE_SPEED: begin
                if (is_digit) begin
                    speed_goal = goal_ccw ? -value : value;
                    drive_mode = MODE_TERM;
                end
            end
            MODE_TERM: begin
                if (ch == CH_H) begin
                    if (speed_cur < 0) speed_goal = -speed_goal;
                end else if (ch == CH_A) begin
                    if (speed_cur > 0) speed_goal = -speed_goal;
                end else if (is_digit) begin
                    speed_goal = (speed_cur < 0) ? -value : value;
                end else if (ch == CH_S) begin
                    drive_mode = MODE_STOPPED;
                    speed_goal = 0;
                end
            end
            MODE_POT: begin
                if (ch == CH_S) begin
                    drive_mode = MODE_STOPPED;
                    speed_goal = 0;
                end
            end
            default: ;
        endcase
    endtask

    // control tick: pot map, then ramp toward the goal without overshoot
    task automatic take_tick(input logic [11:0] adc);
        if (drive_mode == MODE_POT)
            speed_goal = ((2 * int'(adc) - 4095) * 100) / 4095;
        if (speed_cur < speed_goal) begin
            speed_cur += step_cfg;
            if (speed_cur > speed_goal) speed_cur = speed_goal;
        end else if (speed_cur > speed_goal) begin
            speed_cur -= step_cfg;
            if (speed_cur < speed_goal) speed_cur = speed_goal;
        end
    endtask

    // pwm tick: count down, else toggle phase, skipping an empty phase
    task automatic take_pwm();
        bit nxt_high;
        int len;
        if (phase_left > 1) begin
            phase_left--;
        end else begin
            nxt_high = !phase_high;
            len = phase_length(nxt_high);
            if (len == 0) begin
                nxt_high = !nxt_high;
                len = phase_length(nxt_high);
            end
            phase_high = nxt_high;
            phase_left = len;
        end
    endtask

    function automatic result_t drive_outputs();
        result_t r;
        r.speed_now    = 8'(speed_cur);
        r.duty_percent = 7'(magnitude(speed_cur));
        r.drive_cw     = phase_high && speed_cur > 0;
        r.drive_ccw    = phase_high && speed_cur <= 0;
        r.mode_now     = drive_mode;
        return r;
    endfunction

    task automatic check_field(input string label, input int want, input int seen);
        if (want != seen) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, label, want, seen);
        end
    endtask

    // watch all three ports at the rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            drive_mode  = MODE_STOPPED;
            speed_cur   = 0;
            speed_goal  = 0;
            goal_ccw    = 1'b0;
            phase_high  = 1'b0;
            phase_left  = 0;
            step_cfg    = int'(RAMP_STEP_RST);
            tpp_cfg     = int'(TICKS_PCT_RST);
            mismatches  = 0;
            pending_results.delete();
        end else begin
            // register writes
            if (cfg_wr_en) begin
                if (cfg_index == CFG_RAMP_STEP) step_cfg = int'(cfg_wdata[6:0]);
                else tpp_cfg = int'(cfg_wdata);
            end

            // accepted input word
            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    FUNC_CHAR: take_char(s_tdata[7:0]);
                    FUNC_TICK: take_tick(s_tdata[19:8]);
                    FUNC_PWM:  take_pwm();
                    default: ;
                endcase
                pending_results.push_back(drive_outputs());
            end

            // accepted result word
            if (m_tvalid && m_tready) begin
                seen_word = result_t'(m_tdata[19:0]);
                if (pending_results.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: result word with nothing predicted, expected none, got %h",
                             $time, m_tdata);
                end else begin
                    want_word = pending_results.pop_front();
                    check_field("speed_now", int'(want_word.speed_now),
                                int'(seen_word.speed_now));
                    check_field("duty_percent", int'(want_word.duty_percent),
                                int'(seen_word.duty_percent));
                    check_field("drive_cw", int'(want_word.drive_cw), int'(seen_word.drive_cw));
                    check_field("drive_ccw", int'(want_word.drive_ccw),
                                int'(seen_word.drive_ccw));
                    check_field("mode_now", int'(want_word.mode_now), int'(seen_word.mode_now));
                end
            end
        end
        outstanding = pending_results.size();
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the bidirectional motor ramp PWM drive. A short
// directed sequence walks the mode machine, then randomized sessions (stop,
// ramp down, rearm, terminal or potentiometer run with PWM bursts and noise)
// run under several register settings, with random gaps on both channels.
// ----------------------------------------------------------------------------

module testbench;
    import bmr_pkg::*;

    localparam logic [1:0] FUNC_UNUSED  = 2'd3;
    localparam int         PHASE_WORDS  = 100;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         CYCLE_LIMIT  = 200000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;      // [7:0] char_code, [19:8] adc_sample, zero pad
    logic [1:0]  s_tuser = '0;      // [1:0] func
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;           // [7:0] speed_now, [14:8] duty_percent, [15] drive_cw,
                                    // [16] drive_ccw, [19:17] mode_now, zero pad
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_wdata = '0;

    int mismatches;
    int outstanding;
    int cycle_count = 0;
    int words_sent = 0;
    int kind_count [4] = '{0, 0, 0, 0};
    int settings_used = 1;
    int ramp_now = int'(RAMP_STEP_RST);
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;

    always #2 aclk = ~aclk;

    bidirectional_motor_ramp_pwm_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    motor_drive_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due", cycle_count, outstanding);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: random stalls, two long hold-offs to back the drive up
    initial begin : result_sink
        int gap;
        int taken;
        taken = 0;
        @(negedge aclk);
        while (!aresetn) @(negedge aclk);
        forever begin
            if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
            gap = rx_calm ? 0 : $urandom_range(0, 11);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            taken++;
            @(negedge aclk);
            if (taken == 200 || taken == 450) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
        end
    end

    // one input word; starts and ends at a falling edge, tvalid left high
    task automatic send_word(input logic [1:0] kind, input logic [7:0] ch,
                             input logic [11:0] adc);
        int gap;
        if ($urandom_range(0, 31) == 0) tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0000, adc, ch};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        words_sent++;
        kind_count[kind]++;
        @(negedge aclk);
    endtask

    // unused fields carry random bits
    task automatic send_char(input logic [7:0] ch);
        send_word(FUNC_CHAR, ch, 12'($urandom_range(0, 4095)));
    endtask

    task automatic send_tick(input logic [11:0] adc);
        send_word(FUNC_TICK, 8'($urandom_range(0, 255)), adc);
    endtask

    task automatic send_pwm();
        send_word(FUNC_PWM, 8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095)));
    endtask

    // pot samples, with the ends and the midpoint now and then
    function automatic logic [11:0] pick_adc();
        case ($urandom_range(0, 11))
            0: return 12'd0;
            1: return 12'd4095;
            2: return 12'd2047;
            3: return 12'd2048;
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic logic [7:0] pick_digit();
        int n;
        n = $urandom_range(4, 9);
        return (n == 4) ? CH_0 : 8'(int'(CH_0) + n);
    endfunction

    // terminal-mode commands and near misses
    function automatic logic [7:0] pick_command();
        case ($urandom_range(0, 11))
            0, 1: return CH_H;
            2, 3: return CH_A;
            4:    return CH_S;
            5:    return 8'(int'(CH_0) + $urandom_range(1, 4));
            6:    return CH_STAR;
            7:    return ($urandom_range(0, 1) != 0) ? CH_P : CH_T;
            default: return pick_digit();
        endcase
    endfunction

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic configure(input logic [6:0] ramp, input logic [15:0] tpp);
        wait_idle();
        write_reg(CFG_RAMP_STEP, {9'b0, ramp});
        write_reg(CFG_TICKS_PCT, tpp);
        ramp_now = int'(ramp);
        settings_used++;
    endtask

    // stop, ramp toward zero, rearm, then one terminal or pot session
    task automatic run_session();
        int n;
        int pick;
        if ($urandom_range(0, 9) != 0) send_char(CH_S);
        n = (ramp_now == 0) ? 2 : 200 / ramp_now + 1;
        if (n > 40) n = 40;
        repeat (n) send_tick(pick_adc());
        if ($urandom_range(0, 9) != 0) send_char(CH_STAR);
        if ($urandom_range(0, 1) != 0) begin
            send_char(CH_P);
        end else begin
            send_char(CH_T);
            send_char(($urandom_range(0, 1) != 0) ? CH_H : CH_A);
            send_char(pick_digit());
        end
        repeat ($urandom_range(10, 30)) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) send_pwm();
            else if (pick < 62) send_tick(pick_adc());
            else if (pick < 85) send_char(pick_command());
            else if (pick < 90) repeat ($urandom_range(10, 40)) send_pwm();
            else if (pick < 97) send_char(8'($urandom_range(0, 255)));
            else send_word(FUNC_UNUSED, 8'($urandom_range(0, 255)),
                           12'($urandom_range(0, 4095)));
        end
    endtask

    task automatic run_phase();
        int start;
        start = words_sent;
        while (words_sent - start < PHASE_WORDS) run_session();
    endtask

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // directed walk through the modes at the reset register values
        send_word(FUNC_UNUSED, 8'hFF, 12'hFFF);
        send_char(CH_STAR);
        send_char(CH_P);
        send_tick(12'd4095);
        send_tick(12'd0);
        send_tick(12'd2047);
        send_tick(12'd2048);
        send_pwm();
        send_char(CH_S);
        send_char(CH_STAR);
        send_char(CH_T);
        send_char(CH_H);
        send_char(CH_9);
        send_tick(12'd0);
        send_tick(12'hFFF);
        send_char(CH_A);
        send_char(CH_0);
        send_char(8'(int'(CH_0) + 7));
        send_char(8'h00);
        send_char(8'hFF);
        send_pwm();
        send_char(CH_S);
        // speed not yet back to zero, so this rearm is refused
        send_char(CH_STAR);

        // random sessions across register settings, extremes included
        configure(7'd1, 16'd1);
        run_phase();
        configure(7'd100, 16'd0);
        run_phase();
        configure(7'd0, 16'd2);
        run_phase();
        configure(7'd127, 16'd1);
        run_phase();
        configure(7'($urandom_range(1, 100)), 16'd65535);
        run_phase();
        configure(7'($urandom_range(1, 100)), 16'($urandom_range(1, 4)));
        run_phase();

        wait_idle();
        repeat (8) @(negedge aclk);

        $display("sent %0d words: %0d commands, %0d control ticks, %0d pwm ticks, %0d unused kind",
                 words_sent, kind_count[FUNC_CHAR], kind_count[FUNC_TICK],
                 kind_count[FUNC_PWM], kind_count[FUNC_UNUSED]);
        $display("%0d register settings, %0d mismatches", settings_used, mismatches);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
